// ===== design/ebms_pkg.sv =====
// Shared constants, codes and types of the exact block match scanner.
package ebms_pkg;

   localparam int PATTERN_MAX   = 64;
   localparam int POSITION_BITS = 32;
   localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int OFFSET_BITS   = 32;
   localparam int COUNT_BITS    = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_TEXT    = 1'b1;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic CSR_REPORT_ALL = 1'b0;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_AMBIGUOUS = 2'd2
   } status_type;

   typedef struct packed {
      logic pat_shift;
      logic txt_shift;
      logic txt_clear;
   } cell_ctl_type;

   typedef struct packed {
      logic                mode;
      logic                last;
      logic                hit;
      logic [LEN_BITS-1:0] length;
   } item_type;

   typedef struct packed {
      logic                   kind;
      logic [OFFSET_BITS-1:0] offset;
      logic [COUNT_BITS-1:0]  count;
      status_type             status;
      logic                   done_res;
   } result_type;

endpackage

// ===== design/exact_block_match_scanner.sv =====
// Top level of the exact block match scanner: cell chain, bookkeeping and result queue.
// A match report or summary is registered in the s1 stage, then in the result queue.
// One beat per cycle while the result queue has room; the compare is combinational.
// A last text beat that itself completes a match while every match is reported yields
// two results, which drain one per cycle while rsp_ready is high.
// Reset is synchronous and clears the pattern length, scan state and the report-all flag.
module exact_block_match_scanner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [7:0]                          req_data,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [ebms_pkg::OFFSET_BITS-1:0]    rsp_offset,
   output logic [ebms_pkg::COUNT_BITS-1:0]     rsp_count,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_done_res,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ebms_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ebms_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ebms_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic                           allow_ff, allow_in;
   logic                           restart_ff, restart_in;
   logic [ebms_pkg::LEN_BITS-1:0]  length_ff, length_in;
   logic                           s1_valid_ff, s1_valid_in;
   ebms_pkg::item_type             s1_ff, s1_in;

   ebms_pkg::cell_ctl_type         ctl;
   logic [7:0]                     pat [ebms_pkg::PATTERN_MAX];
   logic [7:0]                     win [ebms_pkg::PATTERN_MAX];
   logic [ebms_pkg::PATTERN_MAX-1:0] mask;
   logic [ebms_pkg::PATTERN_MAX-1:0] fill;
   logic [ebms_pkg::PATTERN_MAX-1:0] ok;

   logic                           req_fire;
   logic                           pat_beat;
   logic                           txt_beat;
   logic                           pat_full;
   logic                           hit;
   logic                           advance;
   logic                           room;
   logic                           push0;
   logic                           push1;
   ebms_pkg::result_type           res0;
   ebms_pkg::result_type           res1;
   ebms_pkg::result_type           head;
   logic                           csr_hit;

   assign req_fire = req_valid && req_ready;
   assign pat_beat = req_fire && (req_mode == ebms_pkg::MODE_PATTERN);
   assign txt_beat = req_fire && (req_mode == ebms_pkg::MODE_TEXT);
   assign pat_full = mask[ebms_pkg::PATTERN_MAX-1] && !restart_ff;

   assign ctl.pat_shift = pat_beat && !pat_full;
   assign ctl.txt_shift = txt_beat;
   assign ctl.txt_clear = pat_beat || (txt_beat && req_last);

   for (genvar j = 0; j < ebms_pkg::PATTERN_MAX; j++) begin : g_cell
      if (j == 0) begin : g_head
         ebms_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .pat_prev  (req_data),
            .mask_prev (1'b1),
            .win_prev  (req_data),
            .fill_prev (1'b1),
            .pat       (pat[j]),
            .mask      (mask[j]),
            .win       (win[j]),
            .fill      (fill[j]),
            .ok        (ok[j])
         );
      end else begin : g_body
         ebms_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .pat_prev  (pat[j-1]),
            .mask_prev (mask[j-1] && !restart_ff),
            .win_prev  (win[j-1]),
            .fill_prev (fill[j-1]),
            .pat       (pat[j]),
            .mask      (mask[j]),
            .win       (win[j]),
            .fill      (fill[j]),
            .ok        (ok[j])
         );
      end
   end

   assign hit = mask[0] && (&ok);

   assign advance   = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      length_in  = length_ff;
      restart_in = restart_ff;
      if (pat_beat) begin
         if (restart_ff) begin
            length_in = ebms_pkg::LEN_BITS'(1);
         end else if (!pat_full) begin
            length_in = length_ff + ebms_pkg::LEN_BITS'(1);
         end
         restart_in = req_last;
      end

      s1_valid_in = req_fire || (s1_valid_ff && !advance);
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_in.mode   = req_mode;
         s1_in.last   = req_last;
         s1_in.hit    = hit;
         s1_in.length = length_ff;
      end

      csr_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      allow_in = allow_ff;
      if (csr_hit && (csr_paddr[2] == ebms_pkg::CSR_REPORT_ALL)) begin
         allow_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (reset) begin
         allow_ff    <= 1'b0;
         restart_ff  <= 1'b1;
         length_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         allow_ff    <= allow_in;
         restart_ff  <= restart_in;
         length_ff   <= length_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   ebms_tally u_tally (
      .clock   (clock),
      .reset   (reset),
      .item    (s1_ff),
      .advance (advance),
      .allow   (allow_ff),
      .push0   (push0),
      .push1   (push1),
      .res0    (res0),
      .res1    (res1)
   );

   ebms_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push0 (push0),
      .push1 (push1),
      .data0 (res0),
      .data1 (res1),
      .pop   (rsp_ready),
      .room  (room),
      .valid (rsp_valid),
      .head  (head)
   );

   assign rsp_kind     = head.kind;
   assign rsp_offset   = head.offset;
   assign rsp_count    = head.count;
   assign rsp_status   = head.status;
   assign rsp_done_res = head.done_res;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ebms_pkg::CSR_REPORT_ALL)
                       ? ebms_pkg::CSR_DATA_BITS'(allow_ff) : '0;

endmodule

// ===== design/ebms_cell.sv =====
// One cell of the scan chain: a pattern byte, a text window byte and their compare.
module ebms_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ebms_pkg::cell_ctl_type ctl,
   input  logic [7:0]            pat_prev,
   input  logic                  mask_prev,
   input  logic [7:0]            win_prev,
   input  logic                  fill_prev,
   output logic [7:0]            pat,
   output logic                  mask,
   output logic [7:0]            win,
   output logic                  fill,
   output logic                  ok
);

   logic [7:0] pat_ff, pat_in;
   logic       mask_ff, mask_in;
   logic [7:0] win_ff, win_in;
   logic       fill_ff, fill_in;

   always_comb begin
      pat_in  = pat_ff;
      mask_in = mask_ff;
      win_in  = win_ff;
      fill_in = fill_ff;
      if (ctl.pat_shift) begin
         pat_in  = pat_prev;
         mask_in = mask_prev;
      end
      if (ctl.txt_shift) begin
         win_in  = win_prev;
         fill_in = fill_prev;
      end
      if (ctl.txt_clear) begin
         fill_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      win_ff <= win_in;
      if (reset) begin
         mask_ff <= 1'b0;
         fill_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         fill_ff <= fill_in;
      end
   end

   // The compare looks at the byte that this beat shifts into the cell.
   assign ok   = !mask_ff || (fill_prev && (win_prev == pat_ff));
   assign pat  = pat_ff;
   assign mask = mask_ff;
   assign win  = win_ff;
   assign fill = fill_ff;

endmodule

// ===== design/ebms_tally.sv =====
// Match bookkeeping: skip window, position, count, first offset and result building.
module ebms_tally (
   input  logic                  clock,
   input  logic                  reset,
   input  ebms_pkg::item_type    item,
   input  logic                  advance,
   input  logic                  allow,
   output logic                  push0,
   output logic                  push1,
   output ebms_pkg::result_type  res0,
   output ebms_pkg::result_type  res1
);

   logic [ebms_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic [ebms_pkg::LEN_BITS-1:0]      skip_ff, skip_in;
   logic [ebms_pkg::COUNT_BITS-1:0]    total_ff, total_in;
   logic [ebms_pkg::POSITION_BITS-1:0] first_ff, first_in;

   logic                               is_text;
   logic                               match;
   logic                               summary;
   logic                               report;
   logic [ebms_pkg::POSITION_BITS-1:0] start;
   logic [ebms_pkg::COUNT_BITS-1:0]    total_new;
   logic [ebms_pkg::POSITION_BITS-1:0] first_new;
   ebms_pkg::status_type               status;
   ebms_pkg::result_type               rep_res;
   ebms_pkg::result_type               sum_res;

   always_comb begin
      is_text   = (item.mode == ebms_pkg::MODE_TEXT);
      match     = is_text && (skip_ff == '0) && item.hit;
      summary   = is_text && item.last;
      report    = match && allow;
      start     = pos_ff + ebms_pkg::POSITION_BITS'(1)
                  - ebms_pkg::POSITION_BITS'(item.length);
      total_new = total_ff;
      if (match && (total_ff != ebms_pkg::COUNT_MAX)) begin
         total_new = total_ff + ebms_pkg::COUNT_BITS'(1);
      end
      first_new = (match && (total_ff == '0)) ? start : first_ff;

      if (total_new == '0) begin
         status = ebms_pkg::STATUS_NOT_FOUND;
      end else if (!allow && (total_new >= ebms_pkg::COUNT_BITS'(2))) begin
         status = ebms_pkg::STATUS_AMBIGUOUS;
      end else begin
         status = ebms_pkg::STATUS_FOUND;
      end

      rep_res.kind     = ebms_pkg::KIND_MATCH;
      rep_res.offset   = ebms_pkg::OFFSET_BITS'(start);
      rep_res.count    = total_new;
      rep_res.status   = ebms_pkg::STATUS_FOUND;
      rep_res.done_res = 1'b0;

      sum_res.kind     = ebms_pkg::KIND_SUMMARY;
      sum_res.offset   = (total_new != '0) ? ebms_pkg::OFFSET_BITS'(first_new) : '0;
      sum_res.count    = total_new;
      sum_res.status   = status;
      sum_res.done_res = 1'b1;

      res0  = report ? rep_res : sum_res;
      res1  = sum_res;
      push0 = advance && (report || summary);
      push1 = advance && report && summary;

      pos_in   = pos_ff;
      skip_in  = skip_ff;
      total_in = total_ff;
      first_in = first_ff;
      if (advance) begin
         if (!is_text || item.last) begin
            pos_in   = '0;
            skip_in  = '0;
            total_in = '0;
            first_in = '0;
         end else begin
            if (pos_ff != ebms_pkg::POSITION_MAX) begin
               pos_in = pos_ff + ebms_pkg::POSITION_BITS'(1);
            end
            if (match) begin
               skip_in = item.length - ebms_pkg::LEN_BITS'(1);
            end else if (skip_ff != '0) begin
               skip_in = skip_ff - ebms_pkg::LEN_BITS'(1);
            end
            total_in = total_new;
            first_in = first_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         skip_ff  <= '0;
         total_ff <= '0;
         first_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         total_ff <= total_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== design/ebms_queue.sv =====
// Result queue that takes up to two results per cycle and hands out one per cycle while popped.
module ebms_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push0,
   input  logic                 push1,
   input  ebms_pkg::result_type data0,
   input  ebms_pkg::result_type data1,
   input  logic                 pop,
   output logic                 room,
   output logic                 valid,
   output ebms_pkg::result_type head
);

   ebms_pkg::result_type            entry_ff [ebms_pkg::QUEUE_DEPTH];
   logic [ebms_pkg::QPTR_BITS-1:0]  wr_ff, wr_in;
   logic [ebms_pkg::QPTR_BITS-1:0]  rd_ff, rd_in;
   logic [ebms_pkg::QCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ebms_pkg::QPTR_BITS-1:0]  wr_next;
   logic                            do_pop;

   always_comb begin
      do_pop  = pop && (cnt_ff != '0);
      wr_next = wr_ff + ebms_pkg::QPTR_BITS'(1);
      wr_in   = wr_ff + ebms_pkg::QPTR_BITS'(push0) + ebms_pkg::QPTR_BITS'(push1);
      rd_in   = rd_ff + ebms_pkg::QPTR_BITS'(do_pop);
      cnt_in  = cnt_ff + ebms_pkg::QCNT_BITS'(push0) + ebms_pkg::QCNT_BITS'(push1)
                - ebms_pkg::QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wr_next] <= data1;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign room  = (cnt_ff <= ebms_pkg::QCNT_BITS'(ebms_pkg::QUEUE_DEPTH - 2));
   assign valid = (cnt_ff != '0);
   assign head  = entry_ff[rd_ff];

endmodule
